// File: hw/rtl/chained_free_block_allocator_assert.svh
// Assertion macros for the free block allocator.
// Both expect i_clk and i_rst_n in the scope of use.
`ifndef CHAINED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`define CHAINED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH

// cons holds in the same cycle as ante
`define CFBA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfba assertion failed");

// cons holds in the cycle after ante
`define CFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfba assertion failed");

`endif

// File: hw/rtl/cfba_pkg.sv
`timescale 1ns / 1ps

package cfba_pkg;

    localparam int BLK_W     = 10;
    localparam int OUT_CNT_W = 7;

    localparam logic MODE_FREE  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [BLK_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0]     granted_block;
        logic                 status;
        logic [OUT_CNT_W-1:0] cached_count;
    } t_rsp;

    typedef struct packed {
        logic latch;
        logic push;
        logic pop;
        logic refuse;
        logic pop_capture;
        logic mod_step;
        logic base_load;
        logic flag_take;
        logic copy_start;
        logic copy_run;
        logic spill_end;
        logic clear_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_alloc;
        logic op_alloc;
        logic full;
        logic empty;
        logic mod_skip;
        logic mod_last;
        logic flag_set;
        logic copy_done;
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage

// File: hw/rtl/cfba_stream_if.sv
`timescale 1ns / 1ps

interface cfba_stream_if #(
    parameter type t_data = logic
) ();

    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: hw/rtl/chained_free_block_allocator.sv
// Free, refused: idle, then done; allocate: idle, pop (registered cache read), then done.
// Spill (free into a full cache): row-fold steps, base load, copy of the cache, spill end.
// Reload (allocate empties the cache): the same fold steps, base load, flag check, copy.
// Copies move one cache entry per cycle through single-port-write RAMs.
// Reset: synchronous, active low; then the clear state clears the row flags,
// with the input not ready. One item in flight; the output register frees the input.
`timescale 1ns / 1ps

module chained_free_block_allocator #(
    parameter int CACHE_DEPTH = 64,
    parameter int BLOCK_COUNT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfba_stream_if.sink   i_req,
    cfba_stream_if.source o_rsp
);

    cfba_pkg::t_cmd cmd;
    cfba_pkg::t_sts sts;
    logic           in_ready;
    logic           out_valid;
    cfba_pkg::t_rsp out_data;

    cfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    cfba_dp #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_req.valid),
        .i_req_data  (i_req.data),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = out_data;

endmodule

// File: hw/rtl/cfba_ram.sv
`timescale 1ns / 1ps

module cfba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cfba_ctrl.sv
`timescale 1ns / 1ps

module cfba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfba_pkg::t_sts i_sts,
    output cfba_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_POP       = 9'b000000100,
        S_MOD       = 9'b000001000,
        S_BASE      = 9'b000010000,
        S_FLAG      = 9'b000100000,
        S_COPY      = 9'b001000000,
        S_SPILL_END = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_run = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (!i_sts.in_alloc) begin
                        if (!i_sts.full) begin
                            o_cmd.push = 1'b1;
                            n_state    = S_DONE;
                        end else begin
                            n_state = i_sts.mod_skip ? S_BASE : S_MOD;
                        end
                    end else if (i_sts.empty) begin
                        o_cmd.refuse = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_POP;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_capture = 1'b1;
                if (i_sts.empty) begin
                    n_state = i_sts.mod_skip ? S_BASE : S_MOD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.base_load = 1'b1;
                if (i_sts.op_alloc) begin
                    n_state = S_FLAG;
                end else begin
                    o_cmd.copy_start = 1'b1;
                    n_state          = S_COPY;
                end
            end
            S_FLAG: begin
                o_cmd.flag_take = 1'b1;
                if (i_sts.flag_set) begin
                    o_cmd.copy_start = 1'b1;
                    n_state          = S_COPY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                o_cmd.copy_run = 1'b1;
                if (i_sts.copy_done) begin
                    n_state = i_sts.op_alloc ? S_DONE : S_SPILL_END;
                end
            end
            S_SPILL_END: begin
                o_cmd.spill_end = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/cfba_dp.sv
`timescale 1ns / 1ps

module cfba_dp #(
    parameter int CACHE_DEPTH = 64,
    parameter int BLOCK_COUNT = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfba_pkg::t_cmd i_cmd,
    output cfba_pkg::t_sts o_sts,
    input  logic           i_in_valid,
    input  cfba_pkg::t_req i_req_data,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output cfba_pkg::t_rsp o_out_data
);

    localparam int BLK_W     = cfba_pkg::BLK_W;
    localparam int OUT_CNT_W = cfba_pkg::OUT_CNT_W;
    localparam int IDX_W     = $clog2(CACHE_DEPTH);
    localparam int CNT_W     = $clog2(CACHE_DEPTH + 1);
    localparam int ROW_W     = $clog2(BLOCK_COUNT);
    localparam int LINK_D    = BLOCK_COUNT * CACHE_DEPTH;
    localparam int LA_W      = $clog2(LINK_D);
    localparam int BLK_MAX   = (1 << BLK_W) - 1;
    localparam int MOD_STEPS = $clog2(BLK_MAX / BLOCK_COUNT + 1);
    localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam logic [BLK_W-1:0] MOD_BASE = BLK_W'(BLOCK_COUNT);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CACHE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_SAVED = CNT_W'(CACHE_DEPTH % (1 << OUT_CNT_W));
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(BLOCK_COUNT - 1);

    logic                r_mode;
    logic [BLK_W-1:0]    r_blk;
    logic [CNT_W-1:0]    r_count;
    logic [BLK_W-1:0]    r_rem;
    logic [STEP_W-1:0]   r_step;
    logic [LA_W-1:0]     r_base;
    logic [CNT_W-1:0]    r_rd_idx;
    logic [IDX_W-1:0]    r_wr_idx;
    logic                r_wr_pend;
    logic [ROW_W-1:0]    r_clr;
    logic [BLK_W-1:0]    r_granted;
    logic                r_status;
    logic                r_out_valid;
    cfba_pkg::t_rsp      r_out;

    logic [CNT_W-1:0]         count_dec;
    logic [ROW_W+BLK_W-1:0]   rem_ext;
    logic [ROW_W-1:0]         row;
    logic [STEP_W-1:0]        shamt;
    logic [BLK_W-1:0]         divisor;
    logic [LA_W-1:0]          base_next;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
    logic                     rd_more;

    logic                cache_we;
    logic [IDX_W-1:0]    cache_waddr;
    logic [BLK_W-1:0]    cache_wdata;
    logic [IDX_W-1:0]    cache_raddr;
    logic [BLK_W-1:0]    cache_rdata;

    logic                link_we;
    logic [LA_W-1:0]     link_waddr;
    logic [LA_W-1:0]     link_raddr;
    logic [BLK_W-1:0]    link_rdata;

    logic                flag_we;
    logic [ROW_W-1:0]    flag_waddr;
    logic                flag_wdata;
    logic                flag_rdata;

    assign count_dec = r_count - CNT_W'(1);
    assign rem_ext   = {{ROW_W{1'b0}}, r_rem};
    assign row       = rem_ext[ROW_W-1:0];
    assign shamt     = STEP_W'(MOD_STEPS - 1) - r_step;
    assign divisor   = MOD_BASE << shamt;
    assign base_next = LA_W'(row) * LA_W'(CACHE_DEPTH);
    assign cnt_ext   = {{OUT_CNT_W{1'b0}}, r_count};
    assign rd_more   = (r_rd_idx != CNT_FULL);

    always_comb begin
        cache_we    = 1'b0;
        cache_waddr = r_wr_idx;
        cache_wdata = link_rdata;
        if (i_cmd.push) begin
            cache_we    = 1'b1;
            cache_waddr = r_count[IDX_W-1:0];
            cache_wdata = i_req_data.block_number;
        end else if (i_cmd.spill_end) begin
            cache_we    = 1'b1;
            cache_waddr = '0;
            cache_wdata = r_blk;
        end else if (i_cmd.copy_run && r_wr_pend && r_mode == cfba_pkg::MODE_ALLOC) begin
            cache_we = 1'b1;
        end
    end

    assign cache_raddr = i_cmd.copy_run ? r_rd_idx[IDX_W-1:0] : count_dec[IDX_W-1:0];

    assign link_we    = i_cmd.copy_run && r_wr_pend && r_mode == cfba_pkg::MODE_FREE;
    assign link_waddr = r_base + LA_W'(r_wr_idx);
    assign link_raddr = r_base + LA_W'(r_rd_idx);

    assign flag_we    = i_cmd.clear_run || i_cmd.spill_end;
    assign flag_waddr = i_cmd.clear_run ? r_clr : row;
    assign flag_wdata = !i_cmd.clear_run;

    cfba_ram #(
        .WIDTH (BLK_W),
        .DEPTH (CACHE_DEPTH)
    ) u_cache_ram (
        .i_clk   (i_clk),
        .i_we    (cache_we),
        .i_waddr (cache_waddr),
        .i_wdata (cache_wdata),
        .i_raddr (cache_raddr),
        .o_rdata (cache_rdata)
    );

    cfba_ram #(
        .WIDTH (BLK_W),
        .DEPTH (LINK_D)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (cache_rdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    cfba_ram #(
        .WIDTH (1),
        .DEPTH (BLOCK_COUNT)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (row),
        .o_rdata (flag_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_run) begin
                r_clr <= r_clr + ROW_W'(1);
            end
            if (i_cmd.push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= count_dec;
            end else if (i_cmd.spill_end) begin
                r_count <= CNT_W'(1);
            end else if (i_cmd.flag_take) begin
                r_count <= flag_rdata ? CNT_SAVED : '0;
            end
            if (i_cmd.copy_start) begin
                r_wr_pend <= 1'b0;
            end else if (i_cmd.copy_run) begin
                r_wr_pend <= rd_more;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode    <= i_req_data.mode;
            r_blk     <= i_req_data.block_number;
            r_rem     <= i_req_data.block_number;
            r_step    <= '0;
            r_granted <= '0;
            r_status  <= i_cmd.refuse ? cfba_pkg::STATUS_EMPTY : cfba_pkg::STATUS_DONE;
        end
        if (i_cmd.pop_capture) begin
            r_granted <= cache_rdata;
            r_rem     <= cache_rdata;
        end
        if (i_cmd.mod_step) begin
            if (r_rem >= divisor) begin
                r_rem <= r_rem - divisor;
            end
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.base_load) begin
            r_base <= base_next;
        end
        if (i_cmd.copy_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.copy_run && rd_more) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
            r_wr_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.granted_block <= r_granted;
            r_out.status        <= r_status;
            r_out.cached_count  <= cnt_ext[OUT_CNT_W-1:0];
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.in_valid   = i_in_valid;
        o_sts.in_alloc   = (i_req_data.mode == cfba_pkg::MODE_ALLOC);
        o_sts.op_alloc   = (r_mode == cfba_pkg::MODE_ALLOC);
        o_sts.full       = (r_count == CNT_FULL);
        o_sts.empty      = (r_count == '0);
        o_sts.mod_skip   = (MOD_STEPS == 0);
        o_sts.mod_last   = (r_step == STEP_W'(MOD_STEPS - 1));
        o_sts.flag_set   = flag_rdata;
        o_sts.copy_done  = !rd_more && !r_wr_pend;
        o_sts.clear_last = (r_clr == ROW_LAST);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/cfba_checker.sv
`timescale 1ns / 1ps
`include "chained_free_block_allocator_assert.svh"

module cfba_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cfba_pkg::BLK_W-1:0]     i_granted_block,
    input logic                           i_status,
    input logic [cfba_pkg::OUT_CNT_W-1:0] i_cached_count
);

    `CFBA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `CFBA_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_granted_block) && $stable(i_status) && $stable(i_cached_count))
    `CFBA_ASSERT_SAME(a_refuse_empty, i_out_valid && i_status == cfba_pkg::STATUS_EMPTY, i_granted_block == '0 && i_cached_count == '0)

endmodule

bind chained_free_block_allocator cfba_checker u_cfba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_granted_block (o_rsp.data.granted_block),
    .i_status        (o_rsp.data.status),
    .i_cached_count  (o_rsp.data.cached_count)
);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CACHE_DEPTH = 64;
    localparam int BLOCK_COUNT = 1024;
    localparam int N_DIRECTED  = 24;
    localparam int BLK_W       = cfba_pkg::BLK_W;
    localparam int OUT_CNT_W   = cfba_pkg::OUT_CNT_W;

    typedef struct packed {
        logic                 mode;
        logic [BLK_W-1:0]     blk;
        logic                 typed;
        logic [BLK_W-1:0]     granted;
        logic                 status;
        logic [OUT_CNT_W-1:0] count;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    cfba_stream_if #(.t_data(cfba_pkg::t_req)) req_if ();
    cfba_stream_if #(.t_data(cfba_pkg::t_rsp)) rsp_if ();

    chained_free_block_allocator #(
        .CACHE_DEPTH(CACHE_DEPTH),
        .BLOCK_COUNT(BLOCK_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [BLK_W-1:0] pool_cache [CACHE_DEPTH];
    int               pool_count;
    logic [BLK_W-1:0] chain_rows [BLOCK_COUNT][CACHE_DEPTH];
    int               chain_counts [BLOCK_COUNT];

    cfba_pkg::t_rsp outcome_q [$];
    int   n_errors;
    int   n_items;
    int   n_results;
    int   n_spills;
    int   n_reloads;
    int   n_refused;
    int   src_idle_pct;
    int   snk_idle_pct;

    t_dir_row directed_rows [0:N_DIRECTED-1] = '{
        '{cfba_pkg::MODE_ALLOC, 10'd0,    1'b1, 10'd0,    cfba_pkg::STATUS_EMPTY, 7'd0},
        '{cfba_pkg::MODE_ALLOC, 10'd1023, 1'b1, 10'd0,    cfba_pkg::STATUS_EMPTY, 7'd0},
        '{cfba_pkg::MODE_FREE,  10'd0,    1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd1},
        '{cfba_pkg::MODE_FREE,  10'd1023, 1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd2},
        '{cfba_pkg::MODE_ALLOC, 10'd0,    1'b1, 10'd1023, cfba_pkg::STATUS_DONE,  7'd1},
        '{cfba_pkg::MODE_ALLOC, 10'd1023, 1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd0},
        '{cfba_pkg::MODE_ALLOC, 10'd0,    1'b1, 10'd0,    cfba_pkg::STATUS_EMPTY, 7'd0},
        '{cfba_pkg::MODE_FREE,  10'h2AA,  1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd1},
        '{cfba_pkg::MODE_FREE,  10'h155,  1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd2},
        '{cfba_pkg::MODE_FREE,  10'h3FF,  1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd3},
        '{cfba_pkg::MODE_FREE,  10'h001,  1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd4},
        '{cfba_pkg::MODE_FREE,  10'h200,  1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd5},
        '{cfba_pkg::MODE_ALLOC, 10'h155,  1'b1, 10'h200,  cfba_pkg::STATUS_DONE,  7'd4},
        '{cfba_pkg::MODE_ALLOC, 10'h2AA,  1'b1, 10'h001,  cfba_pkg::STATUS_DONE,  7'd3},
        '{cfba_pkg::MODE_FREE,  10'h100,  1'b1, 10'd0,    cfba_pkg::STATUS_DONE,  7'd4},
        '{cfba_pkg::MODE_ALLOC, 10'h3FF,  1'b1, 10'h100,  cfba_pkg::STATUS_DONE,  7'd3},
        '{cfba_pkg::MODE_ALLOC, 10'h000,  1'b1, 10'h3FF,  cfba_pkg::STATUS_DONE,  7'd2},
        '{cfba_pkg::MODE_ALLOC, 10'h3FF,  1'b1, 10'h155,  cfba_pkg::STATUS_DONE,  7'd1},
        '{cfba_pkg::MODE_ALLOC, 10'h000,  1'b1, 10'h2AA,  cfba_pkg::STATUS_DONE,  7'd0},
        '{cfba_pkg::MODE_ALLOC, 10'h000,  1'b1, 10'd0,    cfba_pkg::STATUS_EMPTY, 7'd0},
        '{cfba_pkg::MODE_FREE,  10'h0F0,  1'b0, 10'd0,    cfba_pkg::STATUS_DONE,  7'd0},
        '{cfba_pkg::MODE_FREE,  10'h30F,  1'b0, 10'd0,    cfba_pkg::STATUS_DONE,  7'd0},
        '{cfba_pkg::MODE_ALLOC, 10'h155,  1'b0, 10'd0,    cfba_pkg::STATUS_DONE,  7'd0},
        '{cfba_pkg::MODE_ALLOC, 10'h2AA,  1'b0, 10'd0,    cfba_pkg::STATUS_DONE,  7'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    function automatic cfba_pkg::t_rsp free_list_step(input cfba_pkg::t_req r);
        cfba_pkg::t_rsp rsp;
        int   row;
        int   n;
        int   i;
        rsp = '0;
        rsp.status = cfba_pkg::STATUS_DONE;
        if (r.mode == cfba_pkg::MODE_FREE) begin
            if (pool_count >= CACHE_DEPTH) begin
                row = r.block_number % BLOCK_COUNT;
                for (i = 0; i < CACHE_DEPTH; i++) begin
                    chain_rows[row][i] = pool_cache[i];
                end
                chain_counts[row] = CACHE_DEPTH % (1 << OUT_CNT_W);
                pool_cache[0] = r.block_number;
                pool_count = 1;
                n_spills++;
            end else begin
                pool_cache[pool_count] = r.block_number;
                pool_count++;
            end
        end else if (pool_count == 0) begin
            rsp.status = cfba_pkg::STATUS_EMPTY;
            n_refused++;
        end else begin
            pool_count--;
            rsp.granted_block = pool_cache[pool_count];
            if (pool_count == 0) begin
                row = rsp.granted_block % BLOCK_COUNT;
                n = (chain_counts[row] > CACHE_DEPTH) ? CACHE_DEPTH : chain_counts[row];
                for (i = 0; i < CACHE_DEPTH; i++) begin
                    pool_cache[i] = chain_rows[row][i];
                end
                pool_count = n;
                if (n != 0) n_reloads++;
            end
        end
        rsp.cached_count = OUT_CNT_W'(pool_count);
        return rsp;
    endfunction

    task automatic issue_request(input cfba_pkg::t_req r, input logic typed,
                                 input cfba_pkg::t_rsp typed_rsp);
        cfba_pkg::t_rsp predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = free_list_step(r);
        outcome_q.push_back(typed ? typed_rsp : predicted);
        n_items++;
    endtask

    task automatic run_random(input int n_target);
        cfba_pkg::t_req r;
        int   sent;
        int   kind;
        int   len;
        int   free_pct;
        sent = 0;
        while (sent < n_target) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                len      = $urandom_range(90, 10);
                free_pct = 90;
            end else if (kind < 70) begin
                len      = $urandom_range(90, 10);
                free_pct = 10;
            end else begin
                len      = $urandom_range(30, 5);
                free_pct = 50;
            end
            repeat (len) begin
                r.mode = ($urandom_range(99) < free_pct) ? cfba_pkg::MODE_FREE
                                                          : cfba_pkg::MODE_ALLOC;
                case ($urandom_range(15))
                    0:       r.block_number = '0;
                    1:       r.block_number = '1;
                    default: r.block_number = BLK_W'($urandom_range(BLOCK_COUNT - 1));
                endcase
                issue_request(r, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cfba_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected item granted_block",
                                int'(rsp_if.data.granted_block), -1);
            end else begin
                want = outcome_q.pop_front();
                if (rsp_if.data.granted_block !== want.granted_block)
                    report_mismatch("granted_block", int'(rsp_if.data.granted_block),
                                    int'(want.granted_block));
                if (rsp_if.data.status !== want.status)
                    report_mismatch("status", int'(rsp_if.data.status), int'(want.status));
                if (rsp_if.data.cached_count !== want.cached_count)
                    report_mismatch("cached_count", int'(rsp_if.data.cached_count),
                                    int'(want.cached_count));
            end
        end
    end

    initial begin
        cfba_pkg::t_req r;
        cfba_pkg::t_rsp typed_rsp;
        n_errors     = 0;
        n_items      = 0;
        n_results    = 0;
        n_spills     = 0;
        n_reloads    = 0;
        n_refused    = 0;
        pool_count   = 0;
        src_idle_pct = 8;
        snk_idle_pct = 88;
        for (int b = 0; b < BLOCK_COUNT; b++) chain_counts[b] = 0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            r.mode                  = directed_rows[k].mode;
            r.block_number          = directed_rows[k].blk;
            typed_rsp.granted_block = directed_rows[k].granted;
            typed_rsp.status        = directed_rows[k].status;
            typed_rsp.cached_count  = directed_rows[k].count;
            issue_request(r, directed_rows[k].typed, typed_rsp);
        end

        run_random(360);
        src_idle_pct = 88;
        snk_idle_pct = 8;
        run_random(360);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(360);

        @(posedge i_clk);
        req_if.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results, %0d mismatches.",
                 n_items, n_results, n_errors);
        $display("Exercised %0d spills into link blocks, %0d reloads, %0d empty refusals.",
                 n_spills, n_reloads, n_refused);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
